>>> rtl/core/ipv4rx_pkg.sv
package ipv4rx_pkg;

   localparam int PROTOCOL_SLOTS = 4;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = $clog2(4 * (PROTOCOL_SLOTS + 1));
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_LOCAL_ADDRESS = CSR_IDX_W'(0);
   localparam int                   REG_SLOT_BASE     = 1;

   localparam logic [8:0] SLOT_UNUSED = 9'd256;

   typedef enum logic [2:0] {
      ST_ACCEPT       = 3'd0,
      ST_BAD_VERSION  = 3'd1,
      ST_BAD_IHL      = 3'd2,
      ST_TOO_LONG     = 3'd3,
      ST_NOT_ADDRESSED = 3'd4,
      ST_UNKNOWN_PROTO = 3'd5,
      ST_BAD_CHECKSUM = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_of_packet;
      logic [15:0] frame_length;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic        is_broadcast;
      logic [15:0] ident;
      logic [7:0]  type_of_service;
      logic [15:0] fragment_offset;
      logic [2:0]  frag_flags;
      logic [5:0]  header_length;
      logic [15:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0]                         local_address;
      logic [PROTOCOL_SLOTS-1:0][8:0]      protocol_slot;
   } cfg_type;

endpackage

>>> rtl/core/ipv4rx_csr.sv
module ipv4rx_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ipv4rx_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ipv4rx_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ipv4rx_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready,
   output ipv4rx_pkg::cfg_type                 cfg
);

   ipv4rx_pkg::cfg_type                  cfg_ff, cfg_in;
   logic [ipv4rx_pkg::CSR_IDX_W-1:0]     idx;
   logic                                 wr_en;

   assign idx        = csr_paddr[ipv4rx_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         if (idx == ipv4rx_pkg::REG_LOCAL_ADDRESS) begin
            cfg_in.local_address = csr_pwdata;
         end
         for (int i = 0; i < ipv4rx_pkg::PROTOCOL_SLOTS; i++) begin
            if (idx == ipv4rx_pkg::CSR_IDX_W'(ipv4rx_pkg::REG_SLOT_BASE + i)) begin
               cfg_in.protocol_slot[i] = csr_pwdata[8:0];
            end
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (idx == ipv4rx_pkg::REG_LOCAL_ADDRESS) begin
         csr_prdata = cfg_ff.local_address;
      end
      for (int i = 0; i < ipv4rx_pkg::PROTOCOL_SLOTS; i++) begin
         if (idx == ipv4rx_pkg::CSR_IDX_W'(ipv4rx_pkg::REG_SLOT_BASE + i)) begin
            csr_prdata = {(ipv4rx_pkg::CSR_DATA_W - 9)'(0), cfg_ff.protocol_slot[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_address <= '0;
         for (int i = 0; i < ipv4rx_pkg::PROTOCOL_SLOTS; i++) begin
            cfg_ff.protocol_slot[i] <= ipv4rx_pkg::SLOT_UNUSED;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/ipv4rx_hdr.sv
module ipv4rx_hdr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  ipv4rx_pkg::req_type  item,
   input  ipv4rx_pkg::cfg_type  cfg,
   output logic                 res_valid,
   output ipv4rx_pkg::rsp_type  res
);

   logic [5:0]  byte_position_ff, byte_position_in;
   logic [5:0]  header_bytes_ff, header_bytes_in;
   logic [15:0] ones_sum_ff, ones_sum_in;
   logic [7:0]  high_byte_hold_ff, high_byte_hold_in;
   logic [15:0] frame_size_hold_ff, frame_size_hold_in;
   logic [15:0] total_length_hold_ff, total_length_hold_in;
   logic [15:0] ident_hold_ff, ident_hold_in;
   logic [7:0]  tos_hold_ff, tos_hold_in;
   logic [15:0] flags_offset_hold_ff, flags_offset_hold_in;
   logic [7:0]  protocol_hold_ff, protocol_hold_in;
   logic [31:0] source_hold_ff, source_hold_in;
   logic [31:0] dest_hold_ff, dest_hold_in;
   logic        verdict_given_ff, verdict_given_in;

   logic [7:0]  b;
   logic        start, active, early, last, bcast, proto_ok;
   logic [5:0]  pos, hb_n;
   logic [16:0] sum_wide;
   logic [6:0]  pos_next;
   ipv4rx_pkg::status_type early_st, st;

   assign b     = item.data_byte;
   assign start = item.start_of_packet;
   assign pos   = start ? 6'd0 : byte_position_ff;
   assign active = item_valid && (start || !verdict_given_ff);

   always_comb begin
      early    = 1'b0;
      early_st = ipv4rx_pkg::ST_BAD_VERSION;
      if (pos == 6'd0) begin
         if (b[7:4] != 4'd4) begin
            early = 1'b1;
         end else if (b[3:0] < 4'd5) begin
            early    = 1'b1;
            early_st = ipv4rx_pkg::ST_BAD_IHL;
         end
      end
   end

   always_comb begin
      frame_size_hold_in   = start ? item.frame_length : frame_size_hold_ff;
      high_byte_hold_in    = start ? 8'd0 : high_byte_hold_ff;
      ones_sum_in          = start ? 16'd0 : ones_sum_ff;
      byte_position_in     = pos;
      verdict_given_in     = verdict_given_ff;
      header_bytes_in      = header_bytes_ff;
      total_length_hold_in = total_length_hold_ff;
      ident_hold_in        = ident_hold_ff;
      tos_hold_in          = tos_hold_ff;
      flags_offset_hold_in = flags_offset_hold_ff;
      protocol_hold_in     = protocol_hold_ff;
      source_hold_in       = source_hold_ff;
      dest_hold_in         = dest_hold_ff;
      sum_wide             = '0;
      hb_n                 = header_bytes_ff;
      if (pos == 6'd0) begin
         hb_n = {b[3:0], 2'b00};
      end
      pos_next = {1'b0, pos} + 7'd1;
      last     = !early && (pos_next >= {1'b0, hb_n});

      if (!early) begin
         header_bytes_in = hb_n;
         unique case (pos)
            6'd1:                            tos_hold_in = b;
            6'd2, 6'd3:                      total_length_hold_in = {total_length_hold_ff[7:0], b};
            6'd4, 6'd5:                      ident_hold_in = {ident_hold_ff[7:0], b};
            6'd6, 6'd7:                      flags_offset_hold_in = {flags_offset_hold_ff[7:0], b};
            6'd9:                            protocol_hold_in = b;
            6'd12, 6'd13, 6'd14, 6'd15:      source_hold_in = {source_hold_ff[23:0], b};
            6'd16, 6'd17, 6'd18, 6'd19:      dest_hold_in = {dest_hold_ff[23:0], b};
            default: ;
         endcase
         if (!pos[0]) begin
            high_byte_hold_in = b;
         end else begin
            sum_wide    = {1'b0, ones_sum_in} + {1'b0, high_byte_hold_in, b};
            ones_sum_in = sum_wide[15:0] + {15'd0, sum_wide[16]};
         end
         byte_position_in = pos_next[5:0];
      end
      if (early || last) begin
         verdict_given_in = 1'b1;
      end else if (start) begin
         verdict_given_in = 1'b0;
      end
   end

   always_comb begin
      proto_ok = 1'b0;
      for (int i = 0; i < ipv4rx_pkg::PROTOCOL_SLOTS; i++) begin
         if (cfg.protocol_slot[i] == {1'b0, protocol_hold_in}) begin
            proto_ok = 1'b1;
         end
      end
      bcast = (dest_hold_in == 32'hFFFF_FFFF);
      priority if (total_length_hold_in > frame_size_hold_in) begin
         st = ipv4rx_pkg::ST_TOO_LONG;
      end else if (!bcast && (dest_hold_in == 32'd0 || dest_hold_in != cfg.local_address)) begin
         st = ipv4rx_pkg::ST_NOT_ADDRESSED;
      end else if (!proto_ok) begin
         st = ipv4rx_pkg::ST_UNKNOWN_PROTO;
      end else if (ones_sum_in != 16'hFFFF) begin
         st = ipv4rx_pkg::ST_BAD_CHECKSUM;
      end else begin
         st = ipv4rx_pkg::ST_ACCEPT;
      end
   end

   always_comb begin
      res_valid = active && (early || last);
      if (early) begin
         res        = '0;
         res.status = early_st;
      end else begin
         res.status          = st;
         res.protocol        = protocol_hold_in;
         res.source_address  = source_hold_in;
         res.is_broadcast    = bcast;
         res.ident           = ident_hold_in;
         res.type_of_service = tos_hold_in;
         res.fragment_offset = {flags_offset_hold_in[12:0], 3'b000};
         res.frag_flags      = flags_offset_hold_in[15:13];
         res.header_length   = hb_n;
         res.payload_length  = (total_length_hold_in > {10'd0, hb_n}) ?
                               (total_length_hold_in - {10'd0, hb_n}) : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff     <= '0;
         header_bytes_ff      <= '0;
         ones_sum_ff          <= '0;
         high_byte_hold_ff    <= '0;
         frame_size_hold_ff   <= '0;
         total_length_hold_ff <= '0;
         ident_hold_ff        <= '0;
         tos_hold_ff          <= '0;
         flags_offset_hold_ff <= '0;
         protocol_hold_ff     <= '0;
         source_hold_ff       <= '0;
         dest_hold_ff         <= '0;
         verdict_given_ff     <= 1'b1;
      end else if (active) begin
         byte_position_ff     <= byte_position_in;
         header_bytes_ff      <= header_bytes_in;
         ones_sum_ff          <= ones_sum_in;
         high_byte_hold_ff    <= high_byte_hold_in;
         frame_size_hold_ff   <= frame_size_hold_in;
         total_length_hold_ff <= total_length_hold_in;
         ident_hold_ff        <= ident_hold_in;
         tos_hold_ff          <= tos_hold_in;
         flags_offset_hold_ff <= flags_offset_hold_in;
         protocol_hold_ff     <= protocol_hold_in;
         source_hold_ff       <= source_hold_in;
         dest_hold_ff         <= dest_hold_in;
         verdict_given_ff     <= verdict_given_in;
      end
   end

endmodule

>>> rtl/core/ipv4_receive_header_check.sv
// IPv4 receive header checker. Takes a packet one byte per transaction, the first
// byte marked by req_data.start_of_packet together with the received frame size,
// and gives one verdict transaction per packet: at the last header byte (IHL*4),
// or at byte 0 on a bad version or an IHL below 5. Checks run in order: version,
// IHL, total length against frame size, destination (broadcast or a non-zero
// match of the local address), protocol against the configured slots, header
// checksum. Bytes outside a header give no transaction. One byte is taken every
// cycle unless req_stall holds it; a byte passes through the input register and
// its verdict is registered in the output register, which drives the rsp_ channel.
// Configuration must be written only while idle; the block does not enforce it.
module ipv4_receive_header_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ipv4rx_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ipv4rx_pkg::rsp_type                 rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ipv4rx_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ipv4rx_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ipv4rx_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   ipv4rx_pkg::cfg_type  cfg;
   ipv4rx_pkg::req_type  in_data_ff;
   ipv4rx_pkg::rsp_type  out_data_ff, res;
   logic                 in_valid_ff, out_valid_ff, res_valid, advance;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   ipv4rx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ipv4rx_hdr u_hdr (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff && advance),
      .item       (in_data_ff),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff && res_valid) begin
         out_data_ff <= res;
      end
   end

endmodule
